[sv/uvs_pkg.sv]
package uvs_pkg;

  localparam int MAX_DIVISIONS_DEF = 128;
  localparam int NORMAL_BITS_DEF   = 16;

  localparam int GRID_W   = 8;
  localparam int CFG_W    = 23;
  localparam int CIDX_W   = 3;
  localparam int RADIUS_W = 23;
  localparam int LONEXT_W = 17;
  localparam int LATEXT_W = 16;
  localparam int TEX_W    = 17;
  localparam int POS_W    = 24;
  localparam int IDX_W    = 15;

  localparam logic [CIDX_W-1:0] REG_ROW_COUNT        = 3'd0;
  localparam logic [CIDX_W-1:0] REG_COLUMN_COUNT     = 3'd1;
  localparam logic [CIDX_W-1:0] REG_SPHERE_RADIUS    = 3'd2;
  localparam logic [CIDX_W-1:0] REG_LONGITUDE_EXTENT = 3'd3;
  localparam logic [CIDX_W-1:0] REG_LATITUDE_EXTENT  = 3'd4;

  localparam logic KIND_VERTEX = 1'b0;
  localparam logic KIND_QUAD   = 1'b1;

  localparam logic [GRID_W-1:0]   ROWS_RST   = 8'd30;
  localparam logic [GRID_W-1:0]   COLS_RST   = 8'd30;
  localparam logic [RADIUS_W-1:0] RADIUS_RST = 23'd65536;
  localparam logic [LONEXT_W-1:0] LONEXT_RST = 17'd92160;
  localparam logic [LATEXT_W-1:0] LATEXT_RST = 16'd46080;

  localparam logic [GRID_W-1:0]   DIV_MIN    = 8'd3;
  localparam logic [RADIUS_W-1:0] RADIUS_MIN = 23'd66;
  localparam logic [RADIUS_W-1:0] RADIUS_MAX = 23'd6553600;
  localparam logic [LONEXT_W-1:0] LONEXT_MIN = 17'd256;
  localparam logic [LONEXT_W-1:0] LONEXT_MAX = 17'd92160;
  localparam logic [LATEXT_W-1:0] LATEXT_MIN = 16'd256;
  localparam logic [LATEXT_W-1:0] LATEXT_MAX = 16'd46080;

  // divider lanes
  localparam int DIV_LANES = 4;
  localparam int LANE_LON  = 0;
  localparam int LANE_U    = 1;
  localparam int LANE_LAT  = 2;
  localparam int LANE_V    = 3;
  localparam int NUM_W     = 25;
  localparam int DEN_W     = 8;
  localparam int QUO_W     = 17;

  // cordic lanes
  localparam int CORDIC_LANES = 2;
  localparam int CL_LAT       = 0;
  localparam int CL_LON       = 1;
  localparam int CORDIC_STEPS = 16;
  localparam int ZW           = 25;
  localparam int XW           = 34;
  localparam int ANG_W        = 27;
  localparam int UNIT_W       = 32;
  localparam int PROD_W       = 56;

  localparam logic signed [XW-1:0]    CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [XW-1:0]    ONE_Q30     = 34'sd1073741824;
  localparam logic signed [ANG_W-1:0] DEG90       = 27'sd5898240;
  localparam logic signed [ANG_W-1:0] DEG180      = 27'sd11796480;
  localparam logic signed [ANG_W-1:0] DEG360      = 27'sd23592960;
  localparam logic signed [PROD_W-1:0] POS_HALF   = 56'sd536870912;
  localparam logic signed [PROD_W-1:0] POS_LIMIT  = 56'sd6553600;

  typedef struct packed {
    logic vld;
    logic en;
  } pipe_ctl_t;

  typedef struct packed {
    logic              kind;
    logic [GRID_W-1:0] row;
    logic [GRID_W-1:0] col;
  } div_tag_t;

  typedef struct packed {
    div_tag_t         grid;
    logic [TEX_W-1:0] tex_u;
    logic [TEX_W-1:0] tex_v;
    logic             flip_lat;
    logic             flip_lon;
  } cordic_tag_t;

  typedef struct packed {
    logic signed [ZW-1:0] z;
    logic                 flip;
  } angle_t;

  function automatic logic signed [ZW-1:0] atan_deg16(int i);
    logic signed [ZW-1:0] r;
    case (i)
      0:       r = 25'sd2949120;
      1:       r = 25'sd1740968;
      2:       r = 25'sd919879;
      3:       r = 25'sd466945;
      4:       r = 25'sd234379;
      5:       r = 25'sd117302;
      6:       r = 25'sd58666;
      7:       r = 25'sd29335;
      8:       r = 25'sd14668;
      9:       r = 25'sd7334;
      10:      r = 25'sd3667;
      11:      r = 25'sd1833;
      12:      r = 25'sd917;
      13:      r = 25'sd458;
      14:      r = 25'sd229;
      15:      r = 25'sd115;
      default: r = '0;
    endcase
    return r;
  endfunction

  // wrap to the half turn, fold into the right half plane
  function automatic angle_t reduce_angle(logic signed [ANG_W-1:0] a);
    logic signed [ANG_W-1:0] t;
    angle_t r;
    t = a;
    if (t > DEG180) begin
      t = t - DEG360;
    end else if (t <= -DEG180) begin
      t = t + DEG360;
    end
    r.flip = 1'b0;
    if (t > DEG90) begin
      t = t - DEG180;
      r.flip = 1'b1;
    end else if (t < -DEG90) begin
      t = t + DEG180;
      r.flip = 1'b1;
    end
    r.z = t[ZW-1:0];
    return r;
  endfunction

  function automatic logic signed [UNIT_W-1:0] sat_unit(logic signed [XW-1:0] v, logic flip);
    logic signed [XW-1:0] t;
    t = v;
    if (t > ONE_Q30) begin
      t = ONE_Q30;
    end else if (t < -ONE_Q30) begin
      t = -ONE_Q30;
    end
    if (flip) begin
      t = -t;
    end
    return t[UNIT_W-1:0];
  endfunction

  function automatic logic signed [POS_W-1:0] to_pos(logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] t;
    t = (p + POS_HALF) >>> 30;
    if (t > POS_LIMIT) begin
      t = POS_LIMIT;
    end else if (t < -POS_LIMIT) begin
      t = -POS_LIMIT;
    end
    return t[POS_W-1:0];
  endfunction

endpackage

[sv/uvs_div.sv]
module uvs_div #(
  parameter int TAG_W = 17
) (
  input  logic                                              clk,
  input  logic                                              rst,
  input  uvs_pkg::pipe_ctl_t                                ctl,
  input  logic [uvs_pkg::DIV_LANES-1:0][uvs_pkg::NUM_W-1:0] num,
  input  logic [uvs_pkg::DIV_LANES-1:0][uvs_pkg::DEN_W-1:0] den,
  input  logic [TAG_W-1:0]                                  tag_in,
  output logic                                              out_vld,
  output logic [uvs_pkg::DIV_LANES-1:0][uvs_pkg::QUO_W-1:0] quo,
  output logic [TAG_W-1:0]                                  tag_out
);
  import uvs_pkg::*;

  logic                                vld_r [QUO_W];
  logic [DIV_LANES-1:0][NUM_W-1:0] rem_r [QUO_W];
  logic [DIV_LANES-1:0][QUO_W-1:0] quo_r [QUO_W];
  logic [TAG_W-1:0]                    tag_r [QUO_W];

  // one quotient bit per stage, msb first
  for (genvar s = 0; s < QUO_W; s++) begin : g_stage
    localparam int B = QUO_W - 1 - s;
    logic                            vld_i;
    logic [DIV_LANES-1:0][NUM_W-1:0] rem_i;
    logic [DIV_LANES-1:0][QUO_W-1:0] quo_i;
    logic [TAG_W-1:0]                tag_i;
    logic [DIV_LANES-1:0][NUM_W-1:0] rem_next;
    logic [DIV_LANES-1:0][QUO_W-1:0] quo_next;

    if (s == 0) begin : g_first
      assign vld_i = ctl.vld;
      assign rem_i = num;
      assign quo_i = '0;
      assign tag_i = tag_in;
    end else begin : g_next
      assign vld_i = vld_r[s-1];
      assign rem_i = rem_r[s-1];
      assign quo_i = quo_r[s-1];
      assign tag_i = tag_r[s-1];
    end

    always_comb begin
      logic [NUM_W-1:0] sh;
      for (int l = 0; l < DIV_LANES; l++) begin
        sh = NUM_W'(den[l]) << B;
        if (rem_i[l] >= sh) begin
          rem_next[l] = rem_i[l] - sh;
          quo_next[l] = quo_i[l] | (QUO_W'(1) << B);
        end else begin
          rem_next[l] = rem_i[l];
          quo_next[l] = quo_i[l];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_r[s] <= 1'b0;
      end else if (ctl.en) begin
        vld_r[s] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      if (ctl.en) begin
        rem_r[s] <= rem_next;
        quo_r[s] <= quo_next;
        tag_r[s] <= tag_i;
      end
    end
  end

  assign out_vld = vld_r[QUO_W-1];
  assign quo     = quo_r[QUO_W-1];
  assign tag_out = tag_r[QUO_W-1];

endmodule

[sv/uvs_cordic.sv]
module uvs_cordic #(
  parameter int TAG_W = 53
) (
  input  logic                              clk,
  input  logic                              rst,
  input  uvs_pkg::pipe_ctl_t                ctl,
  input  logic signed [uvs_pkg::ZW-1:0]     z_in [uvs_pkg::CORDIC_LANES],
  input  logic [TAG_W-1:0]                  tag_in,
  output logic                              out_vld,
  output logic signed [uvs_pkg::XW-1:0]     x_out [uvs_pkg::CORDIC_LANES],
  output logic signed [uvs_pkg::XW-1:0]     y_out [uvs_pkg::CORDIC_LANES],
  output logic [TAG_W-1:0]                  tag_out
);
  import uvs_pkg::*;

  logic                 vld_r [CORDIC_STEPS];
  logic signed [XW-1:0] x_r   [CORDIC_STEPS][CORDIC_LANES];
  logic signed [XW-1:0] y_r   [CORDIC_STEPS][CORDIC_LANES];
  logic signed [ZW-1:0] z_r   [CORDIC_STEPS][CORDIC_LANES];
  logic [TAG_W-1:0]     tag_r [CORDIC_STEPS];

  for (genvar s = 0; s < CORDIC_STEPS; s++) begin : g_stage
    localparam logic signed [ZW-1:0] ATAN = atan_deg16(s);
    logic                 vld_i;
    logic signed [XW-1:0] x_i [CORDIC_LANES];
    logic signed [XW-1:0] y_i [CORDIC_LANES];
    logic signed [ZW-1:0] z_i [CORDIC_LANES];
    logic [TAG_W-1:0]     tag_i;
    logic signed [XW-1:0] x_next [CORDIC_LANES];
    logic signed [XW-1:0] y_next [CORDIC_LANES];
    logic signed [ZW-1:0] z_next [CORDIC_LANES];

    if (s == 0) begin : g_first
      assign vld_i = ctl.vld;
      assign tag_i = tag_in;
      for (genvar l = 0; l < CORDIC_LANES; l++) begin : g_lane
        assign x_i[l] = CORDIC_GAIN;
        assign y_i[l] = '0;
        assign z_i[l] = z_in[l];
      end
    end else begin : g_next
      assign vld_i = vld_r[s-1];
      assign tag_i = tag_r[s-1];
      for (genvar l = 0; l < CORDIC_LANES; l++) begin : g_lane
        assign x_i[l] = x_r[s-1][l];
        assign y_i[l] = y_r[s-1][l];
        assign z_i[l] = z_r[s-1][l];
      end
    end

    always_comb begin
      for (int l = 0; l < CORDIC_LANES; l++) begin
        if (z_i[l] >= 0) begin
          x_next[l] = x_i[l] - (y_i[l] >>> s);
          y_next[l] = y_i[l] + (x_i[l] >>> s);
          z_next[l] = z_i[l] - ATAN;
        end else begin
          x_next[l] = x_i[l] + (y_i[l] >>> s);
          y_next[l] = y_i[l] - (x_i[l] >>> s);
          z_next[l] = z_i[l] + ATAN;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_r[s] <= 1'b0;
      end else if (ctl.en) begin
        vld_r[s] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      if (ctl.en) begin
        for (int l = 0; l < CORDIC_LANES; l++) begin
          x_r[s][l] <= x_next[l];
          y_r[s][l] <= y_next[l];
          z_r[s][l] <= z_next[l];
        end
        tag_r[s] <= tag_i;
      end
    end
  end

  assign out_vld = vld_r[CORDIC_STEPS-1];
  assign tag_out = tag_r[CORDIC_STEPS-1];
  for (genvar l = 0; l < CORDIC_LANES; l++) begin : g_out
    assign x_out[l] = x_r[CORDIC_STEPS-1][l];
    assign y_out[l] = y_r[CORDIC_STEPS-1][l];
  end

endmodule

[sv/uv_sphere_mesh_generator_top.sv]
// an item passes the entry stage, a 17 stage divider pipeline, angle preparation,
// a 16 stage cordic pipeline, clamp and unfold, normal and radius products, output
// register; one vertex request per cycle unless stalled, a quad takes two transfers
// a stalled output holds the whole pipeline in place, nothing is dropped or repeated
// synchronous reset clears all valid bits and loads the register defaults
module uv_sphere_mesh_generator_top #(
  parameter int MAX_DIVISIONS = uvs_pkg::MAX_DIVISIONS_DEF,
  parameter int NORMAL_BITS   = uvs_pkg::NORMAL_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [uvs_pkg::CIDX_W-1:0]        cfg_index,
  input  logic [uvs_pkg::CFG_W-1:0]         cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              kind,
  input  logic [uvs_pkg::GRID_W-1:0]        grid_row,
  input  logic [uvs_pkg::GRID_W-1:0]        grid_col,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [NORMAL_BITS-1:0]     normal_x,
  output logic signed [NORMAL_BITS-1:0]     normal_y,
  output logic signed [NORMAL_BITS-1:0]     normal_z,
  output logic signed [uvs_pkg::POS_W-1:0]  pos_x,
  output logic signed [uvs_pkg::POS_W-1:0]  pos_y,
  output logic signed [uvs_pkg::POS_W-1:0]  pos_z,
  output logic [uvs_pkg::TEX_W-1:0]         tex_u,
  output logic [uvs_pkg::TEX_W-1:0]         tex_v,
  output logic [uvs_pkg::IDX_W-1:0]         corner_a,
  output logic [uvs_pkg::IDX_W-1:0]         corner_b,
  output logic [uvs_pkg::IDX_W-1:0]         corner_c,
  output logic                              last
);
  import uvs_pkg::*;

  localparam logic [GRID_W-1:0] DIV_MAX =
    (MAX_DIVISIONS > 255) ? 8'd255 : GRID_W'(MAX_DIVISIONS);
  localparam int NSH = 31 - NORMAL_BITS;
  localparam logic signed [32:0] NHALF = 33'((1 << (NSH - 1)));
  localparam logic signed [32:0] NMAX  = 33'((1 << (NORMAL_BITS - 1)) - 1);
  localparam logic signed [32:0] NMIN  = -33'((1 << (NORMAL_BITS - 1)));

  function automatic logic signed [NORMAL_BITS-1:0] to_normal(logic signed [UNIT_W-1:0] n);
    logic signed [32:0] t;
    t = (33'(n) + NHALF) >>> NSH;
    if (t > NMAX) begin
      t = NMAX;
    end else if (t < NMIN) begin
      t = NMIN;
    end
    return t[NORMAL_BITS-1:0];
  endfunction

  // configuration registers
  logic [GRID_W-1:0]   row_count;
  logic [GRID_W-1:0]   column_count;
  logic [RADIUS_W-1:0] sphere_radius;
  logic [LONEXT_W-1:0] longitude_extent;
  logic [LATEXT_W-1:0] latitude_extent;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count        <= ROWS_RST;
      column_count     <= COLS_RST;
      sphere_radius    <= RADIUS_RST;
      longitude_extent <= LONEXT_RST;
      latitude_extent  <= LATEXT_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_ROW_COUNT:        row_count        <= cfg_data[GRID_W-1:0];
        REG_COLUMN_COUNT:     column_count     <= cfg_data[GRID_W-1:0];
        REG_SPHERE_RADIUS:    sphere_radius    <= cfg_data[RADIUS_W-1:0];
        REG_LONGITUDE_EXTENT: longitude_extent <= cfg_data[LONEXT_W-1:0];
        REG_LATITUDE_EXTENT:  latitude_extent  <= cfg_data[LATEXT_W-1:0];
        default: ;
      endcase
    end
  end

  logic [GRID_W-1:0]   rows_c;
  logic [GRID_W-1:0]   cols_c;
  logic [RADIUS_W-1:0] radius_c;
  logic [LONEXT_W-1:0] lonext_c;
  logic [LATEXT_W-1:0] latext_c;

  always_comb begin
    rows_c   = (row_count < DIV_MIN) ? DIV_MIN :
               ((row_count > DIV_MAX) ? DIV_MAX : row_count);
    cols_c   = (column_count < DIV_MIN) ? DIV_MIN :
               ((column_count > DIV_MAX) ? DIV_MAX : column_count);
    radius_c = (sphere_radius < RADIUS_MIN) ? RADIUS_MIN :
               ((sphere_radius > RADIUS_MAX) ? RADIUS_MAX : sphere_radius);
    lonext_c = (longitude_extent < LONEXT_MIN) ? LONEXT_MIN :
               ((longitude_extent > LONEXT_MAX) ? LONEXT_MAX : longitude_extent);
    latext_c = (latitude_extent < LATEXT_MIN) ? LATEXT_MIN :
               ((latitude_extent > LATEXT_MAX) ? LATEXT_MAX : latitude_extent);
  end

  logic adv;

  // entry stage: clamp and form the dividends
  logic                            e_vld;
  logic [DIV_LANES-1:0][NUM_W-1:0] e_num;
  div_tag_t                        e_tag;
  logic [GRID_W-1:0]               row_v;
  logic [GRID_W-1:0]               col_v;
  logic [GRID_W-1:0]               row_q;
  logic [GRID_W-1:0]               col_q;

  always_comb begin
    row_v = (grid_row > rows_c) ? rows_c : grid_row;
    col_v = (grid_col > cols_c) ? cols_c : grid_col;
    row_q = (grid_row > rows_c - 8'd1) ? rows_c - 8'd1 : grid_row;
    col_q = (grid_col > cols_c - 8'd1) ? cols_c - 8'd1 : grid_col;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e_vld <= 1'b0;
    end else if (adv) begin
      e_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e_num[LANE_LON] <= NUM_W'(col_v) * NUM_W'(lonext_c);
      e_num[LANE_U]   <= NUM_W'(col_v) << 16;
      e_num[LANE_LAT] <= NUM_W'(row_v) * NUM_W'(latext_c);
      e_num[LANE_V]   <= NUM_W'(row_v) << 16;
      e_tag.kind      <= kind;
      e_tag.row       <= row_q;
      e_tag.col       <= col_q;
    end
  end

  // divider pipeline
  pipe_ctl_t                       div_ctl;
  logic [DIV_LANES-1:0][DEN_W-1:0] div_den;
  logic                            d_vld;
  logic [DIV_LANES-1:0][QUO_W-1:0] d_quo;
  div_tag_t                        d_tag;

  assign div_ctl.vld       = e_vld;
  assign div_ctl.en        = adv;
  assign div_den[LANE_LON] = cols_c;
  assign div_den[LANE_U]   = cols_c;
  assign div_den[LANE_LAT] = rows_c;
  assign div_den[LANE_V]   = rows_c;

  uvs_div #(
    .TAG_W($bits(div_tag_t))
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .ctl     (div_ctl),
    .num     (e_num),
    .den     (div_den),
    .tag_in  (e_tag),
    .out_vld (d_vld),
    .quo     (d_quo),
    .tag_out (d_tag)
  );

  // angle preparation
  logic                 p_vld;
  logic signed [ZW-1:0] p_z [CORDIC_LANES];
  cordic_tag_t          p_tag;
  angle_t               ang_lat;
  angle_t               ang_lon;

  always_comb begin
    logic signed [ANG_W-1:0] a_lat;
    logic signed [ANG_W-1:0] a_lon;
    a_lat = $signed(ANG_W'(d_quo[LANE_LAT])) - $signed(ANG_W'(latext_c[LATEXT_W-1:1]));
    a_lat = a_lat <<< 8;
    a_lon = $signed(ANG_W'(d_quo[LANE_LON]) << 8);
    ang_lat = reduce_angle(a_lat);
    ang_lon = reduce_angle(a_lon);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_vld <= 1'b0;
    end else if (adv) begin
      p_vld <= d_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_z[CL_LAT]    <= ang_lat.z;
      p_z[CL_LON]    <= ang_lon.z;
      p_tag.grid     <= d_tag;
      p_tag.tex_u    <= d_quo[LANE_U];
      p_tag.tex_v    <= d_quo[LANE_V];
      p_tag.flip_lat <= ang_lat.flip;
      p_tag.flip_lon <= ang_lon.flip;
    end
  end

  // sine and cosine
  pipe_ctl_t            cor_ctl;
  logic                 c_vld;
  logic signed [XW-1:0] c_x [CORDIC_LANES];
  logic signed [XW-1:0] c_y [CORDIC_LANES];
  cordic_tag_t          c_tag;

  assign cor_ctl.vld = p_vld;
  assign cor_ctl.en  = adv;

  uvs_cordic #(
    .TAG_W($bits(cordic_tag_t))
  ) u_cordic (
    .clk     (clk),
    .rst     (rst),
    .ctl     (cor_ctl),
    .z_in    (p_z),
    .tag_in  (p_tag),
    .out_vld (c_vld),
    .x_out   (c_x),
    .y_out   (c_y),
    .tag_out (c_tag)
  );

  // clamp and unfold
  logic                     s_vld;
  logic signed [UNIT_W-1:0] s_clat;
  logic signed [UNIT_W-1:0] s_slat;
  logic signed [UNIT_W-1:0] s_clon;
  logic signed [UNIT_W-1:0] s_slon;
  cordic_tag_t              s_tag;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_vld <= 1'b0;
    end else if (adv) begin
      s_vld <= c_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s_clat <= sat_unit(c_x[CL_LAT], c_tag.flip_lat);
      s_slat <= sat_unit(c_y[CL_LAT], c_tag.flip_lat);
      s_clon <= sat_unit(c_x[CL_LON], c_tag.flip_lon);
      s_slon <= sat_unit(c_y[CL_LON], c_tag.flip_lon);
      s_tag  <= c_tag;
    end
  end

  // normal products
  logic                     m_vld;
  logic signed [UNIT_W-1:0] m_nx;
  logic signed [UNIT_W-1:0] m_ny;
  logic signed [UNIT_W-1:0] m_nz;
  cordic_tag_t              m_tag;
  logic signed [63:0]       px;
  logic signed [63:0]       pz;

  assign px = 64'(s_clat) * 64'(s_slon);
  assign pz = 64'(s_clat) * 64'(s_clon);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_vld <= 1'b0;
    end else if (adv) begin
      m_vld <= s_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_nx  <= px[61:30];
      m_ny  <= s_slat;
      m_nz  <= pz[61:30];
      m_tag <= s_tag;
    end
  end

  // radius products, normal rounding, quad corners
  logic                          q_vld;
  logic signed [PROD_W-1:0]      q_px;
  logic signed [PROD_W-1:0]      q_py;
  logic signed [PROD_W-1:0]      q_pz;
  logic signed [NORMAL_BITS-1:0] q_nx;
  logic signed [NORMAL_BITS-1:0] q_ny;
  logic signed [NORMAL_BITS-1:0] q_nz;
  logic                          q_kind;
  logic [TEX_W-1:0]              q_u;
  logic [TEX_W-1:0]              q_v;
  logic [IDX_W-1:0]              q_tl;
  logic [IDX_W-1:0]              q_tr;
  logic [IDX_W-1:0]              q_bl;
  logic [IDX_W-1:0]              q_br;
  logic signed [PROD_W-1:0]      radius_s;
  logic [GRID_W:0]               pitch;
  logic [16:0]                   base;
  logic [IDX_W-1:0]              tl;
  logic [IDX_W-1:0]              bl;

  always_comb begin
    radius_s = $signed(PROD_W'(radius_c));
    pitch    = {1'b0, cols_c} + 9'd1;
    base     = 17'(m_tag.grid.row) * 17'(pitch) + 17'(m_tag.grid.col);
    tl       = base[IDX_W-1:0];
    bl       = tl + IDX_W'(pitch);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_vld <= 1'b0;
    end else if (adv) begin
      q_vld <= m_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      q_px   <= radius_s * PROD_W'(m_nx);
      q_py   <= radius_s * PROD_W'(m_ny);
      q_pz   <= radius_s * PROD_W'(m_nz);
      q_nx   <= to_normal(m_nx);
      q_ny   <= to_normal(m_ny);
      q_nz   <= to_normal(m_nz);
      q_kind <= m_tag.grid.kind;
      q_u    <= m_tag.tex_u;
      q_v    <= m_tag.tex_v;
      q_tl   <= tl;
      q_tr   <= tl + 15'd1;
      q_bl   <= bl;
      q_br   <= bl + 15'd1;
    end
  end

  // output register, a quad holds it for two transfers
  logic                          o_phase;
  logic                          o_kind;
  logic signed [NORMAL_BITS-1:0] o_nx;
  logic signed [NORMAL_BITS-1:0] o_ny;
  logic signed [NORMAL_BITS-1:0] o_nz;
  logic signed [POS_W-1:0]       o_px;
  logic signed [POS_W-1:0]       o_py;
  logic signed [POS_W-1:0]       o_pz;
  logic [TEX_W-1:0]              o_u;
  logic [TEX_W-1:0]              o_v;
  logic [IDX_W-1:0]              o_tl;
  logic [IDX_W-1:0]              o_tr;
  logic [IDX_W-1:0]              o_bl;
  logic [IDX_W-1:0]              o_br;
  logic                          vertex;

  assign vertex = (q_kind == KIND_VERTEX);
  assign adv    = !out_valid || (!out_stall && last);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      o_phase   <= 1'b0;
    end else if (adv) begin
      out_valid <= q_vld;
      o_phase   <= 1'b0;
    end else if (!out_stall) begin
      o_phase   <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      o_kind <= q_kind;
      o_nx   <= vertex ? q_nx : '0;
      o_ny   <= vertex ? q_ny : '0;
      o_nz   <= vertex ? q_nz : '0;
      o_px   <= vertex ? to_pos(q_px) : '0;
      o_py   <= vertex ? to_pos(q_py) : '0;
      o_pz   <= vertex ? to_pos(q_pz) : '0;
      o_u    <= vertex ? q_u : '0;
      o_v    <= vertex ? q_v : '0;
      o_tl   <= vertex ? '0 : q_tl;
      o_tr   <= vertex ? '0 : q_tr;
      o_bl   <= vertex ? '0 : q_bl;
      o_br   <= vertex ? '0 : q_br;
    end
  end

  assign in_stall = !adv;
  assign normal_x = o_nx;
  assign normal_y = o_ny;
  assign normal_z = o_nz;
  assign pos_x    = o_px;
  assign pos_y    = o_py;
  assign pos_z    = o_pz;
  assign tex_u    = o_u;
  assign tex_v    = o_v;
  assign corner_a = o_phase ? o_tr : o_tl;
  assign corner_b = o_bl;
  assign corner_c = o_phase ? o_br : o_tr;
  assign last     = (o_kind == KIND_VERTEX) || o_phase;

`ifndef ASSERT_OFF
  a_stall_needs_result: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with no result held");

  a_first_then_second: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last && !out_stall |=> out_valid && last)
    else $error("first triangle not followed by second");

  a_second_same_corner_b: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last && !out_stall |=> $stable(corner_b))
    else $error("shared corner changed between triangles");

  a_quad_zero_geometry: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> normal_x == 0 && pos_y == 0 && tex_u == 0)
    else $error("quad result carries geometry");
`endif

endmodule

[test/tb.sv]
`timescale 1ns / 1ps

module tb;
  import uvs_pkg::*;

  typedef struct {
    logic signed [15:0] nx, ny, nz;
    logic signed [23:0] px, py, pz;
    logic [16:0] u, v;
    logic [14:0] ca, cb, cc;
    logic lst;
  } vertex_out_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [CIDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic kind = 1'b0;
  logic [GRID_W-1:0] grid_row = '0, grid_col = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [15:0] normal_x, normal_y, normal_z;
  logic signed [23:0] pos_x, pos_y, pos_z;
  logic [16:0] tex_u, tex_v;
  logic [14:0] corner_a, corner_b, corner_c;
  logic last;

  int errors = 0;
  int send_idle = 0;
  int recv_stall = 0;
  bit hold_off = 0;
  int stalls[4] = '{0, 0, 86, 86};
  int idles[4] = '{0, 86, 0, 10};

  always #1 clk = ~clk;

  uv_sphere_mesh_generator_top u_top (.*);

  task automatic report(string what, longint got, longint want);
    errors++;
    $display("mismatch %s got %0d want %0d", what, got, want);
  endtask

  class mesh_board;
    vertex_out_t pending[$];
    longint rows_r = 30, cols_r = 30, radius_r = 65536, lonext_r = 92160, latext_r = 46080;
    longint atan_tab[16] = '{2949120, 1740968, 919879, 466945, 234379, 117302, 58666,
                             29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115};

    function longint clampl(longint x, longint lo, longint hi);
      return x < lo ? lo : (x > hi ? hi : x);
    endfunction

    function longint rshift(longint x, int s);
      return x + (longint'(1) << (s - 1)) >>> s;
    endfunction

    function void sincos(longint a, output longint c, output longint s);
      longint x, y, z, nx;
      bit flip;
      x = 652032874; y = 0; flip = 0;
      while (a > 11796480) a -= 23592960;
      while (a <= -11796480) a += 23592960;
      if (a > 5898240) begin
        a -= 11796480; flip = 1;
      end else if (a < -5898240) begin
        a += 11796480; flip = 1;
      end
      z = a;
      for (int i = 0; i < 16; i++) begin
        if (z >= 0) begin
          nx = x - (y >>> i); y = y + (x >>> i); z -= atan_tab[i];
        end else begin
          nx = x + (y >>> i); y = y - (x >>> i); z += atan_tab[i];
        end
        x = nx;
      end
      x = clampl(x, -(1 << 30), 1 << 30);
      y = clampl(y, -(1 << 30), 1 << 30);
      c = flip ? -x : x;
      s = flip ? -y : y;
    endfunction

    function void write_reg(int idx, longint val);
      case (idx)
        REG_ROW_COUNT:        rows_r = val & 'hFF;
        REG_COLUMN_COUNT:     cols_r = val & 'hFF;
        REG_SPHERE_RADIUS:    radius_r = val & 'h7FFFFF;
        REG_LONGITUDE_EXTENT: lonext_r = val & 'h1FFFF;
        REG_LATITUDE_EXTENT:  latext_r = val & 'hFFFF;
        default: ;
      endcase
    endfunction

    function void note_input(logic k, longint row, longint col);
      vertex_out_t e;
      longint rows, cols, rad, lonx, latx, lon, lat, cl, sl, co, so, n[3];
      longint p;
      rows = clampl(rows_r, 3, 128);
      cols = clampl(cols_r, 3, 128);
      e = '{default: 0};
      if (k == KIND_VERTEX) begin
        rad = clampl(radius_r, 66, 6553600);
        lonx = clampl(lonext_r, 256, 92160);
        latx = clampl(latext_r, 256, 46080);
        row = clampl(row, 0, rows);
        col = clampl(col, 0, cols);
        lon = col * lonx / cols;
        lat = row * latx / rows - latx / 2;
        sincos(lat * 256, cl, sl);
        sincos(lon * 256, co, so);
        n[0] = (cl * so) >>> 30;
        n[1] = sl;
        n[2] = (cl * co) >>> 30;
        e.nx = 16'(clampl(rshift(n[0], 15), -32768, 32767));
        e.ny = 16'(clampl(rshift(n[1], 15), -32768, 32767));
        e.nz = 16'(clampl(rshift(n[2], 15), -32768, 32767));
        e.px = 24'(clampl(rshift(rad * n[0], 30), -6553600, 6553600));
        e.py = 24'(clampl(rshift(rad * n[1], 30), -6553600, 6553600));
        e.pz = 24'(clampl(rshift(rad * n[2], 30), -6553600, 6553600));
        e.u = 17'((col << 16) / cols);
        e.v = 17'((row << 16) / rows);
        e.lst = 1;
        pending = {pending, e};
      end else begin
        row = clampl(row, 0, rows - 1);
        col = clampl(col, 0, cols - 1);
        p = cols + 1;
        e.ca = 15'(row * p + col);
        e.cb = 15'((row + 1) * p + col);
        e.cc = 15'(row * p + col + 1);
        pending = {pending, e};
        e.ca = 15'(row * p + col + 1);
        e.cb = 15'((row + 1) * p + col);
        e.cc = 15'((row + 1) * p + col + 1);
        e.lst = 1;
        pending = {pending, e};
      end
    endfunction

    task check_result(vertex_out_t g);
      vertex_out_t w;
      if (pending.size() == 0) begin
        report("unexpected result", 0, 0);
        return;
      end
      w = pending.pop_front();
      if (g.nx !== w.nx) report("normal_x", g.nx, w.nx);
      if (g.ny !== w.ny) report("normal_y", g.ny, w.ny);
      if (g.nz !== w.nz) report("normal_z", g.nz, w.nz);
      if (g.px !== w.px) report("pos_x", g.px, w.px);
      if (g.py !== w.py) report("pos_y", g.py, w.py);
      if (g.pz !== w.pz) report("pos_z", g.pz, w.pz);
      if (g.u !== w.u) report("tex_u", g.u, w.u);
      if (g.v !== w.v) report("tex_v", g.v, w.v);
      if (g.ca !== w.ca) report("corner_a", g.ca, w.ca);
      if (g.cb !== w.cb) report("corner_b", g.cb, w.cb);
      if (g.cc !== w.cc) report("corner_c", g.cc, w.cc);
      if (g.lst !== w.lst) report("last", g.lst, w.lst);
    endtask
  endclass

  mesh_board board = new();

  // output side
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        board.check_result('{normal_x, normal_y, normal_z, pos_x, pos_y, pos_z,
                             tex_u, tex_v, corner_a, corner_b, corner_c, last});
      end
      out_stall <= hold_off || ($urandom_range(99) < recv_stall);
    end
  end

  task automatic write_cfg(int idx, longint val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= CIDX_W'(idx);
    cfg_data <= CFG_W'(val);
    board.write_reg(idx, val);
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  // called at a rising edge, returns at the edge of the transfer with valid still high
  task automatic send_grid(logic k, logic [7:0] r, logic [7:0] c);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    grid_row <= r;
    grid_col <= c;
    do @(posedge clk); while (in_stall);
    board.note_input(k, r, c);
  endtask

  task automatic random_item;
    logic [7:0] r, c;
    if ($urandom_range(9) < 8) begin
      r = 8'($urandom_range(32'(board.rows_r + 1)));
      c = 8'($urandom_range(32'(board.cols_r + 1)));
    end else begin
      r = 8'($urandom); c = 8'($urandom);
    end
    send_grid(1'($urandom_range(1)), r, c);
  endtask

  task automatic random_config;
    write_cfg(REG_ROW_COUNT, $urandom_range(9) == 0 ? $urandom_range(255) : $urandom_range(3, 20));
    write_cfg(REG_COLUMN_COUNT, $urandom_range(9) == 0 ? $urandom_range(255)
                                                        : $urandom_range(3, 20));
    write_cfg(REG_SPHERE_RADIUS, $urandom);
    write_cfg(REG_LONGITUDE_EXTENT, $urandom);
    write_cfg(REG_LATITUDE_EXTENT, $urandom);
    write_cfg(5 + $urandom_range(2), $urandom);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    // defaults, extremes of fields
    send_grid(KIND_VERTEX, 0, 0);
    send_grid(KIND_VERTEX, 30, 30);
    send_grid(KIND_VERTEX, 255, 255);
    send_grid(KIND_VERTEX, 15, 7);
    send_grid(KIND_QUAD, 0, 0);
    send_grid(KIND_QUAD, 29, 29);
    send_grid(KIND_QUAD, 255, 255);
    drain();
    write_cfg(REG_ROW_COUNT, 128);
    write_cfg(REG_COLUMN_COUNT, 128);
    write_cfg(REG_SPHERE_RADIUS, 6553600);
    write_cfg(REG_LONGITUDE_EXTENT, 92160);
    write_cfg(REG_LATITUDE_EXTENT, 46080);
    send_grid(KIND_VERTEX, 128, 128);
    send_grid(KIND_VERTEX, 64, 32);
    send_grid(KIND_QUAD, 127, 127);
    send_grid(KIND_QUAD, 170, 85);
    drain();
    write_cfg(REG_ROW_COUNT, 0);
    write_cfg(REG_COLUMN_COUNT, 255);
    write_cfg(REG_SPHERE_RADIUS, 0);
    write_cfg(REG_LONGITUDE_EXTENT, 0);
    write_cfg(REG_LATITUDE_EXTENT, 0);
    send_grid(KIND_VERTEX, 2, 100);
    send_grid(KIND_VERTEX, 3, 128);
    send_grid(KIND_QUAD, 5, 200);
    drain();
    write_cfg(REG_ROW_COUNT, 3);
    write_cfg(REG_COLUMN_COUNT, 3);
    write_cfg(REG_SPHERE_RADIUS, 'h7FFFFF);
    write_cfg(REG_LONGITUDE_EXTENT, 'h1FFFF);
    write_cfg(REG_LATITUDE_EXTENT, 'hFFFF);
    send_grid(KIND_VERTEX, 1, 2);
    send_grid(KIND_VERTEX, 3, 3);
    send_grid(KIND_QUAD, 2, 2);
    drain();
    for (int ph = 0; ph < 8; ph++) begin
      recv_stall = stalls[ph % 4];
      send_idle = idles[ph % 4];
      random_config();
      if (ph == 4) begin
        hold_off = 1;
        fork
          begin
            repeat (300) @(posedge clk);
            hold_off = 0;
          end
        join_none
      end
      for (int i = 0; i < 165; i++) begin
        random_item();
        if (i == 80) begin
          in_valid <= 1'b0;
          while (board.pending.size() != 0) @(posedge clk);
        end
      end
      drain();
    end
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end
endmodule
